// File: hw/rtl/qrs_pkg.sv
// Shared constants, types and case codes for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  // word format
  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int MAG_W  = WORD_W;               // magnitude of a word, 2^31 fits
  localparam int PROD_W = 2 * MAG_W;            // b*b and a*c
  localparam int DM_W   = PROD_W + 2;           // |b*b - 4ac|
  localparam int ROOT_W = DM_W / 2 + FRAC_W;    // floor(sqrt(|d| * 2^(2F)))

  // divider operands
  localparam int NUM_W  = 50;                   // -b*2^F +/- s, or c*2^F
  localparam int DEN_W  = MAG_W + 1;            // 2a, or b
  localparam int T_W    = NUM_W + 2;            // 2n + d
  localparam int DD_W   = DEN_W + 1;            // 2d
  localparam int Q_W    = WORD_W + 1;           // quotient bits kept

  // latencies
  localparam int FRONT_LAT = 3;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + 1 + DIV_LAT + 1;

  typedef enum logic [2:0] {
    RC_NONE    = 3'd0,
    RC_LINEAR  = 3'd1,
    RC_TWO     = 3'd2,
    RC_DOUBLE  = 3'd3,
    RC_COMPLEX = 3'd4
  } root_case_t;

  // item data carried alongside the square root
  typedef struct packed {
    root_case_t       kind;
    logic             an;
    logic             bn;
    logic             cn;
    logic [MAG_W-1:0] am;
    logic [MAG_W-1:0] bm;
    logic [MAG_W-1:0] cm;
  } front_sb_t;

  // item data carried alongside the dividers
  typedef struct packed {
    root_case_t kind;
    logic       sg1;
    logic       sg2;
  } back_sb_t;

endpackage
`default_nettype wire

// File: hw/rtl/quadratic_root_solver.sv
// Top level of the fixed-point quadratic root solver.
//
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// Input channel: an item (in_coef_a/b/c) is taken at a rising edge with
// start high and busy low. busy is high only while rst_n is low, so a new
// item may be started in every cycle.
// Result channel: out_valid is high for one cycle with out_root_case,
// out_first_value, out_second_value and out_overflow; the receiver cannot
// hold results off and none is needed, as the pipeline never stalls.
// Pipeline: 3 front stages for decode, multiply and discriminant, 49
// square-root stages, 1 numerator stage, 34 divider stages, 1 output
// stage. Throughput: one item per cycle.
// Results come out in the order the items went in.
// Reset: synchronous, active low; clears all valid bits, so every item in
// flight is dropped and out_valid stays low until new items arrive.
// Saturated results raise out_overflow.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qrs_pkg::WORD_W-1:0] in_coef_a,
  input  logic signed [qrs_pkg::WORD_W-1:0] in_coef_b,
  input  logic signed [qrs_pkg::WORD_W-1:0] in_coef_c,
  output logic                              out_valid,
  output logic [2:0]                        out_root_case,
  output logic signed [qrs_pkg::WORD_W-1:0] out_first_value,
  output logic signed [qrs_pkg::WORD_W-1:0] out_second_value,
  output logic                              out_overflow
);
  import qrs_pkg::*;

  function automatic logic [MAG_W-1:0] mag_of(input logic [WORD_W-1:0] x);
    mag_of = x[WORD_W-1] ? (~x + 1'b1) : x;
  endfunction

  // round-trip of a divider result: sign, saturation, word
  function automatic logic [WORD_W:0] finish(input logic [Q_W-1:0] q, input logic big,
                                             input logic sg);
    logic           neg;
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;
    logic           sat;
    logic [WORD_W-1:0] v;
    neg = sg && (big || q != '0);
    lim = neg ? (Q_W'(1) << (WORD_W-1)) : ((Q_W'(1) << (WORD_W-1)) - 1'b1);
    sat = big || (q > lim);
    mag = sat ? lim : q;
    v   = neg ? (~mag[WORD_W-1:0] + 1'b1) : mag[WORD_W-1:0];
    return {sat, v};
  endfunction

  logic start_ok;
  assign busy     = ~rst_n;
  assign start_ok = start & ~busy;

  // stage 1: decode to sign and magnitude
  logic      vld1_r;
  front_sb_t sb1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start_ok;
    end
    sb1_r.kind <= RC_NONE;
    sb1_r.an   <= in_coef_a[WORD_W-1];
    sb1_r.bn   <= in_coef_b[WORD_W-1];
    sb1_r.cn   <= in_coef_c[WORD_W-1];
    sb1_r.am   <= mag_of(in_coef_a);
    sb1_r.bm   <= mag_of(in_coef_b);
    sb1_r.cm   <= mag_of(in_coef_c);
  end

  // stage 2: products b*b and a*c
  logic              vld2_r;
  front_sb_t         sb2_r;
  logic [PROD_W-1:0] bb2_r;
  logic [PROD_W-1:0] ac2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    sb2_r <= sb1_r;
    bb2_r <= sb1_r.bm * sb1_r.bm;
    ac2_r <= sb1_r.am * sb1_r.cm;
  end

  // stage 3: discriminant magnitude, sign and case
  logic [DM_W-1:0] bb_x, ac4_x, dm_nxt;
  logic            dpos, dzero;
  root_case_t      kind_nxt;
  always_comb begin
    bb_x  = {2'b00, bb2_r};
    ac4_x = {ac2_r, 2'b00};
    dpos  = 1'b0;
    dzero = 1'b0;
    if ((sb2_r.an ^ sb2_r.cn) && sb2_r.cm != '0) begin
      dm_nxt = bb_x + ac4_x;
      dpos   = 1'b1;
    end else if (bb_x > ac4_x) begin
      dm_nxt = bb_x - ac4_x;
      dpos   = 1'b1;
    end else if (bb_x == ac4_x) begin
      dm_nxt = '0;
      dzero  = 1'b1;
    end else begin
      dm_nxt = ac4_x - bb_x;
    end
    if (sb2_r.am == '0) begin
      kind_nxt = (sb2_r.bm == '0) ? RC_NONE : RC_LINEAR;
    end else if (dzero) begin
      kind_nxt = RC_DOUBLE;
    end else if (dpos) begin
      kind_nxt = RC_TWO;
    end else begin
      kind_nxt = RC_COMPLEX;
    end
  end

  logic            vld3_r;
  front_sb_t       sb3_r;
  logic [DM_W-1:0] dm3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    sb3_r.kind <= kind_nxt;
    sb3_r.an   <= sb2_r.an;
    sb3_r.bn   <= sb2_r.bn;
    sb3_r.cn   <= sb2_r.cn;
    sb3_r.am   <= sb2_r.am;
    sb3_r.bm   <= sb2_r.bm;
    sb3_r.cm   <= sb2_r.cm;
    dm3_r      <= dm_nxt;
  end

  // square root of |d| * 2^(2F), side data delayed to match
  logic [ROOT_W-1:0] root;
  qrs_sqrt u_sqrt (
    .clk    (clk),
    .dm_i   (dm3_r),
    .root_o (root)
  );

  front_sb_t sbs_r  [SQRT_LAT];
  logic      vlds_r [SQRT_LAT];
  always_ff @(posedge clk) begin
    sbs_r[0] <= sb3_r;
    for (int i = 1; i < SQRT_LAT; i++) begin
      sbs_r[i] <= sbs_r[i-1];
    end
    if (!rst_n) begin
      for (int i = 0; i < SQRT_LAT; i++) begin
        vlds_r[i] <= 1'b0;
      end
    end else begin
      vlds_r[0] <= vld3_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        vlds_r[i] <= vlds_r[i-1];
      end
    end
  end

  // stage 4: numerators, denominators and result signs
  front_sb_t        sbs;
  logic [NUM_W-1:0] nb, s, nc, diff, sum, n1, n2;
  logic [DEN_W-1:0] den, d1, d2;
  logic             ge, nb_neg, sg1, sg2, rs1, rs2;
  always_comb begin
    sbs    = sbs_r[SQRT_LAT-1];
    nb     = NUM_W'({sbs.bm, {FRAC_W{1'b0}}});
    nc     = NUM_W'({sbs.cm, {FRAC_W{1'b0}}});
    s      = NUM_W'(root);
    den    = {sbs.am, 1'b0};
    ge     = nb >= s;
    diff   = ge ? (nb - s) : (s - nb);
    sum    = nb + s;
    nb_neg = ~sbs.bn;
    n1 = '0; d1 = DEN_W'(1); sg1 = 1'b0;
    n2 = '0; d2 = DEN_W'(1); sg2 = 1'b0;
    rs1 = 1'b0; rs2 = 1'b0;
    case (sbs.kind)
      RC_LINEAR: begin
        n1  = nc;
        d1  = DEN_W'(sbs.bm);
        sg1 = ~sbs.cn ^ sbs.bn;
      end
      RC_TWO: begin
        // -b + s and -b - s as sign and magnitude
        if (nb_neg) begin
          n1 = diff; rs1 = ge;
          n2 = sum;  rs2 = 1'b1;
        end else begin
          n1 = sum;  rs1 = 1'b0;
          n2 = diff; rs2 = ~ge;
        end
        d1  = den;
        d2  = den;
        sg1 = rs1 ^ sbs.an;
        sg2 = rs2 ^ sbs.an;
      end
      RC_DOUBLE: begin
        n1  = nb;
        d1  = den;
        sg1 = nb_neg ^ sbs.an;
      end
      RC_COMPLEX: begin
        n1  = nb;
        d1  = den;
        sg1 = nb_neg ^ sbs.an;
        n2  = s;
        d2  = den;
      end
      default: ;
    endcase
  end

  logic             vld4_r;
  back_sb_t         bsb4_r;
  logic [T_W-1:0]   t1_r, t2_r;
  logic [DD_W-1:0]  dd1_r, dd2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vlds_r[SQRT_LAT-1];
    end
    bsb4_r.kind <= sbs.kind;
    bsb4_r.sg1  <= sg1;
    bsb4_r.sg2  <= sg2;
    // round to nearest: floor((2n + d) / 2d)
    t1_r  <= T_W'({n1, 1'b0}) + T_W'(d1);
    t2_r  <= T_W'({n2, 1'b0}) + T_W'(d2);
    dd1_r <= {d1, 1'b0};
    dd2_r <= {d2, 1'b0};
  end

  // two dividers in parallel
  logic [Q_W-1:0] q1, q2;
  logic           big1, big2;
  qrs_div u_div1 (.clk(clk), .t_i(t1_r), .dd_i(dd1_r), .q_o(q1), .big_o(big1));
  qrs_div u_div2 (.clk(clk), .t_i(t2_r), .dd_i(dd2_r), .q_o(q2), .big_o(big2));

  back_sb_t bsd_r  [DIV_LAT];
  logic     vldd_r [DIV_LAT];
  always_ff @(posedge clk) begin
    bsd_r[0] <= bsb4_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      bsd_r[i] <= bsd_r[i-1];
    end
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vldd_r[i] <= 1'b0;
      end
    end else begin
      vldd_r[0] <= vld4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vldd_r[i] <= vldd_r[i-1];
      end
    end
  end

  // output stage: saturate, apply sign, pick words by case
  back_sb_t        bsd;
  logic [WORD_W:0] f1, f2;
  logic            use1, use2;
  assign bsd  = bsd_r[DIV_LAT-1];
  assign f1   = finish(q1, big1, bsd.sg1);
  assign f2   = finish(q2, big2, bsd.sg2);
  assign use1 = bsd.kind != RC_NONE;
  assign use2 = (bsd.kind == RC_TWO) || (bsd.kind == RC_COMPLEX);

  logic              out_valid_r;
  root_case_t        case_r;
  logic [WORD_W-1:0] first_r, second_r;
  logic              ovf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vldd_r[DIV_LAT-1];
    end
    case_r   <= bsd.kind;
    first_r  <= use1 ? f1[WORD_W-1:0] : '0;
    second_r <= use2 ? f2[WORD_W-1:0] : '0;
    ovf_r    <= (use1 & f1[WORD_W]) | (use2 & f2[WORD_W]);
  end

  assign out_valid        = out_valid_r;
  assign out_root_case    = case_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_overflow     = ovf_r;

endmodule
`default_nettype wire

// File: hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt (
  input  logic                       clk,
  input  logic [qrs_pkg::DM_W-1:0]   dm_i,
  output logic [qrs_pkg::ROOT_W-1:0] root_o
);
  import qrs_pkg::*;

  logic [DM_W-1:0]   rad_r  [ROOT_W];
  logic [ROOT_W:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [DM_W-1:0]   rad_p;
    logic [ROOT_W:0]   rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [ROOT_W+2:0] rem2;
    logic [ROOT_W+2:0] trial;

    if (k == 0) begin : g_first
      assign rad_p  = dm_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    // bring down the next two radicand bits and try a one bit
    assign rem2  = {rem_p, rad_p[DM_W-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};

    always_ff @(posedge clk) begin
      rad_r[k] <= rad_p << 2;
      if (rem2 >= trial) begin
        rem_r[k]  <= ROOT_W'(rem2 - trial) == '0 ? '0 : (ROOT_W+1)'(rem2 - trial);
        root_r[k] <= {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rem2[ROOT_W:0];
        root_r[k] <= {root_p[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div (
  input  logic                    clk,
  input  logic [qrs_pkg::T_W-1:0] t_i,
  input  logic [qrs_pkg::DD_W-1:0] dd_i,
  output logic [qrs_pkg::Q_W-1:0] q_o,
  output logic                    big_o
);
  import qrs_pkg::*;

  localparam int HI_W = T_W - Q_W;

  logic [DD_W-1:0] rem_r [Q_W+1];
  logic [Q_W-1:0]  lo_r  [Q_W+1];
  logic [Q_W-1:0]  q_r   [Q_W+1];
  logic [DD_W-1:0] dd_r  [Q_W+1];
  logic            big_r [Q_W+1];

  logic [DD_W-1:0] hi_ext;
  logic            big_in;

  // quotient too wide for the kept bits when t / 2^Q >= dd
  assign hi_ext = {{(DD_W-HI_W){1'b0}}, t_i[T_W-1:Q_W]};
  assign big_in = hi_ext >= dd_i;

  always_ff @(posedge clk) begin
    rem_r[0] <= big_in ? '0 : hi_ext;
    lo_r[0]  <= t_i[Q_W-1:0];
    q_r[0]   <= '0;
    dd_r[0]  <= dd_i;
    big_r[0] <= big_in;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DD_W:0] rem2;
    logic [DD_W:0] diff;
    logic          ge;

    assign rem2 = {rem_r[k-1], lo_r[k-1][Q_W-1]};
    assign diff = rem2 - {1'b0, dd_r[k-1]};
    assign ge   = rem2 >= {1'b0, dd_r[k-1]};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DD_W-1:0] : rem2[DD_W-1:0];
      lo_r[k]  <= lo_r[k-1] << 1;
      q_r[k]   <= {q_r[k-1][Q_W-2:0], ge};
      dd_r[k]  <= dd_r[k-1];
      big_r[k] <= big_r[k-1];
    end
  end

  assign q_o   = q_r[Q_W];
  assign big_o = big_r[Q_W];

endmodule
`default_nettype wire

// File: hw/rtl/qrs_checker.sv
// Port-level checks for the quadratic root solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [2:0]                 out_root_case,
  input logic [qrs_pkg::WORD_W-1:0] out_first_value,
  input logic [qrs_pkg::WORD_W-1:0] out_second_value,
  input logic                       out_overflow
);
  import qrs_pkg::*;

  // every result comes from an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without an item taken at the pipeline latency");

  // reset drops everything in flight
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // no solution gives zero words and no overflow
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_case == RC_NONE) |->
      (out_first_value == '0 && out_second_value == '0 && !out_overflow))
    else $error("no-solution item with non-zero words");

  // single-root cases leave the second word zero
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_root_case == RC_LINEAR || out_root_case == RC_DOUBLE)) |->
      out_second_value == '0)
    else $error("second word set for a single root");

  // imaginary part is a magnitude
  a_imag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_case == RC_COMPLEX) |-> !out_second_value[WORD_W-1])
    else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_root_case    (out_root_case),
  .out_first_value  (out_first_value),
  .out_second_value (out_second_value),
  .out_overflow     (out_overflow)
);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the quadratic root solver: directed and random items.
`timescale 1ns / 1ps
module tb;
  import qrs_pkg::*;

  typedef struct {
    root_case_t       kind;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic             ovf;
  } roots_t;

  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid, out_overflow;
  logic [2:0] out_root_case;
  logic signed [31:0] out_first_value, out_second_value;

  roots_t roots_due[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int case_seen[5];
  int ovf_seen = 0;
  bit calm = 1'b0;

  quadratic_root_solver dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_root_case(out_root_case),
    .out_first_value(out_first_value), .out_second_value(out_second_value),
    .out_overflow(out_overflow)
  );

  initial forever #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, roots_due.size());
      $display("quadratic_root_solver test failed");
      $finish;
    end
  end

  // floor square root of a wide number, bit by bit
  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [255:0] res, cand;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (256'd1 << i);
      if (cand * cand <= {128'd0, n}) res = cand;
    end
    return res[127:0];
  endfunction

  // round-half-away quotient, saturated to the word
  function automatic logic [31:0] round_div(input logic nneg, input logic [127:0] n,
                                            input logic dneg, input logic [127:0] d,
                                            inout logic ovf);
    logic [127:0] q, lim;
    logic neg;
    q = ((n << 1) + d) / (d << 1);
    neg = (nneg ^ dneg) && (q != 0);
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) begin
      q = lim;
      ovf = 1'b1;
    end
    return neg ? (~q[31:0] + 32'd1) : q[31:0];
  endfunction

  // signed-magnitude sum; a zero sum is positive
  function automatic logic [127:0] sm_add(input logic xn, input logic [127:0] x,
                                          input logic yn, input logic [127:0] y,
                                          output logic rn);
    logic signed [129:0] sx, sy, sum;
    sx = {2'b00, x};
    sy = {2'b00, y};
    if (xn) sx = -sx;
    if (yn) sy = -sy;
    sum = sx + sy;
    rn = sum < 0;
    if (rn) sum = -sum;
    return sum[127:0];
  endfunction

  function automatic roots_t solve_roots(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    roots_t r;
    logic an, bn, cn, rn, ovf;
    logic [31:0] am, bm, cm;
    logic [127:0] bb, ac, dm, den, nb, s, num;
    int dsign;
    an = a[31]; bn = b[31]; cn = c[31];
    am = an ? ~a + 32'd1 : a;
    bm = bn ? ~b + 32'd1 : b;
    cm = cn ? ~c + 32'd1 : c;
    ovf = 1'b0;
    r.first = '0;
    r.second = '0;
    if (am == 0) begin
      if (bm == 0) begin
        r.kind = RC_NONE;
      end else begin
        r.first = round_div(!cn, {96'd0, cm} << FRAC_W, bn, {96'd0, bm}, ovf);
        r.kind = RC_LINEAR;
      end
    end else begin
      bb = {96'd0, bm} * {96'd0, bm};
      ac = ({96'd0, am} * {96'd0, cm}) << 2;
      if ((an ^ cn) && cm != 0) begin
        dm = bb + ac; dsign = 1;
      end else if (bb > ac) begin
        dm = bb - ac; dsign = 1;
      end else if (bb == ac) begin
        dm = '0; dsign = 0;
      end else begin
        dm = ac - bb; dsign = -1;
      end
      den = {96'd0, am} << 1;
      nb = {96'd0, bm} << FRAC_W;
      if (dsign == 0) begin
        r.first = round_div(!bn, nb, an, den, ovf);
        r.kind = RC_DOUBLE;
      end else begin
        s = isqrt(dm << (2 * FRAC_W));
        if (dsign > 0) begin
          num = sm_add(!bn, nb, 1'b0, s, rn);
          r.first = round_div(rn, num, an, den, ovf);
          num = sm_add(!bn, nb, 1'b1, s, rn);
          r.second = round_div(rn, num, an, den, ovf);
          r.kind = RC_TWO;
        end else begin
          r.first = round_div(!bn, nb, an, den, ovf);
          r.second = round_div(1'b0, s, 1'b0, den, ovf);
          r.kind = RC_COMPLEX;
        end
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  // record each accepted item and check each result
  always @(posedge clk) begin
    roots_t e;
    if (rst_n && start && !busy) roots_due.push_back(solve_roots(in_coef_a, in_coef_b, in_coef_c));
    if (rst_n && out_valid) begin
      if (roots_due.size() == 0) begin
        $display("%0t: unexpected result case %0d", $time, out_root_case);
        errors++;
      end else begin
        e = roots_due.pop_front();
        if (out_root_case !== e.kind || out_first_value !== e.first ||
            out_second_value !== e.second || out_overflow !== e.ovf) begin
          $display("%0t: mismatch expected case %0d %0d %0d ovf %0d, got case %0d %0d %0d ovf %0d",
                   $time, e.kind, e.first, e.second, e.ovf, out_root_case,
                   out_first_value, out_second_value, out_overflow);
          errors++;
        end
        if (out_root_case < 5) case_seen[out_root_case]++;
        if (out_overflow) ovf_seen++;
      end
    end
  end

  // send one item, idling now and then unless in a calm stretch
  task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    if (!calm && $urandom_range(99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Q16.16 helper for small whole numbers
  function automatic logic [31:0] fx(input int v);
    return v <<< FRAC_W;
  endfunction

  task automatic test_no_solution();
    send_coefs(0, 0, 0);
    send_coefs(0, 0, fx(5));
    send_coefs(0, 0, 32'h8000_0000);
  endtask

  task automatic test_linear();
    send_coefs(0, fx(2), fx(-6));
    send_coefs(0, fx(-3), fx(1));
    send_coefs(0, 1, 32'h7fff_ffff);
    send_coefs(0, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_two_real();
    send_coefs(fx(1), fx(-3), fx(2));
    send_coefs(fx(-2), fx(1), fx(3));
    send_coefs(fx(1), 0, fx(-4));
  endtask

  task automatic test_double();
    send_coefs(fx(1), fx(-4), fx(4));
    send_coefs(fx(-1), fx(2), fx(-1));
    send_coefs(1, 0, 0);
  endtask

  task automatic test_complex();
    send_coefs(fx(1), fx(2), fx(5));
    send_coefs(fx(-1), 0, fx(-1));
  endtask

  // extremes of the words and saturating results
  task automatic test_extremes();
    send_coefs(1, 32'h7fff_ffff, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(1, 1, 32'h7fff_ffff);
    send_coefs(32'hffff_ffff, 32'h8000_0000, 0);
  endtask

  task automatic test_random(input int count);
    logic [31:0] a, b, c;
    int p, t;
    for (int i = 0; i < count; i++) begin
      calm = (i >= 600 && i < 900);
      case ($urandom_range(5))
        0: begin a = $urandom; b = $urandom; c = $urandom; end
        1: begin
          a = $signed($urandom_range(2000)) - 1000;
          b = $signed($urandom_range(200000)) - 100000;
          c = $signed($urandom_range(200000)) - 100000;
        end
        2: begin
          // exact double root: b*b == 4*a*c
          p = $urandom_range(300, 1);
          t = $signed($urandom_range(400)) - 200;
          if ($urandom_range(1)) p = -p;
          a = p; b = 2 * p * t; c = p * t * t;
        end
        3: begin a = 0; b = $urandom_range(1) ? $urandom : 0; c = $urandom; end
        4: begin a = fx($signed($urandom_range(20)) - 10); b = fx($signed($urandom_range(40)) - 20);
                 c = fx($signed($urandom_range(40)) - 20); end
        default: begin a = $urandom_range(1) ? 32'h8000_0000 : $urandom_range(3);
                       b = $urandom; c = $urandom_range(1) ? 32'h7fff_ffff : $urandom; end
      endcase
      send_coefs(a, b, c);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_solution();
    test_linear();
    test_two_real();
    test_double();
    test_complex();
    test_extremes();
    test_random(1950);
    start <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 20) @(posedge clk);
    $display("%0d items: %0d none, %0d linear, %0d two real, %0d double, %0d complex",
             items_sent, case_seen[0], case_seen[1], case_seen[2], case_seen[3], case_seen[4]);
    $display("%0d results saturated, %0d mismatches", ovf_seen, errors);
    if (errors == 0) begin
      $display("quadratic_root_solver test passed");
    end else begin
      $display("quadratic_root_solver test failed");
    end
    $finish;
  end
endmodule
